[rtl/grwi_pkg.sv]
`default_nettype none

package grwi_pkg;

	localparam int TILE_SIZE_UNITS = 64;
	localparam int ONE_UNIT = 256;
	localparam int TILE_LOG2 = $clog2(TILE_SIZE_UNITS * ONE_UNIT);
	localparam int TILE = 1 << TILE_LOG2;
	localparam int MAP_ROWS = 32;
	localparam int MAP_COLS = 32;
	localparam int ROW_W = $clog2(MAP_ROWS);
	localparam int COL_W = $clog2(MAP_COLS);
	localparam int MAP_DEPTH = MAP_ROWS * MAP_COLS;
	localparam int ADDR_W = $clog2(MAP_DEPTH);
	localparam int STRIP_COUNT = 1024;

	localparam int COORD_W = 20;
	localparam logic [COORD_W-1:0] COORD_MAX = '1;
	localparam int QUARTER = 16384;
	localparam int HALF = 32768;

	localparam int TRIG_W = 20;
	localparam int Z_W = 18;
	localparam int POS_W = 36;
	localparam int DIFF_W = 18;
	localparam int DVD_W = 32;
	localparam int DVS_W = 20;
	localparam int DIST_W = 21;
	localparam int SQ_W = 42;
	localparam int IT_W = 5;
	localparam int CORDIC_ITERS = 16;
	localparam int DIV_ITERS = DVD_W;
	localparam int SQ_ITERS = DIST_W;
	localparam int CORDIC_X0 = 19899;

	localparam logic signed [POS_W-1:0] TILE_S = POS_W'(TILE);
	localparam logic signed [POS_W-1:0] UNIT_S = POS_W'(ONE_UNIT);
	localparam logic signed [POS_W-1:0] MAP_XMAX = POS_W'(TILE * MAP_COLS);
	localparam logic signed [POS_W-1:0] MAP_YMAX = POS_W'(TILE * MAP_ROWS);

	// config register indexes
	localparam logic REG_PLAYER_X = 1'b0;
	localparam logic REG_PLAYER_Y = 1'b1;

	// datapath commands
	localparam logic [4:0] OP_NONE      = 5'd0;
	localparam logic [4:0] OP_CLEAR     = 5'd1;
	localparam logic [4:0] OP_LOAD      = 5'd2;
	localparam logic [4:0] OP_WRITE     = 5'd3;
	localparam logic [4:0] OP_COR_INIT  = 5'd4;
	localparam logic [4:0] OP_COR_STEP  = 5'd5;
	localparam logic [4:0] OP_TRIG_FIX  = 5'd6;
	localparam logic [4:0] OP_SRCH_INIT = 5'd7;
	localparam logic [4:0] OP_DIVA_INIT = 5'd8;
	localparam logic [4:0] OP_DIV_STEP  = 5'd9;
	localparam logic [4:0] OP_DIVA_DONE = 5'd10;
	localparam logic [4:0] OP_DIVB_INIT = 5'd11;
	localparam logic [4:0] OP_DIVB_DONE = 5'd12;
	localparam logic [4:0] OP_PROBE     = 5'd13;
	localparam logic [4:0] OP_CHECK     = 5'd14;
	localparam logic [4:0] OP_MUL_X     = 5'd15;
	localparam logic [4:0] OP_MUL_Y     = 5'd16;
	localparam logic [4:0] OP_SQ_INIT   = 5'd17;
	localparam logic [4:0] OP_SQ_STEP   = 5'd18;
	localparam logic [4:0] OP_SQ_DONE   = 5'd19;
	localparam logic [4:0] OP_OUT       = 5'd20;

	typedef struct packed {
		logic       func;
		logic [4:0] cell_row;
		logic [4:0] cell_col;
		logic [7:0] cell_value;
		logic [15:0] ray_angle;
		logic [9:0] strip_id;
	} req_t;

	typedef struct packed {
		logic [9:0]  strip_out;
		logic [19:0] hit_distance;
		logic [19:0] hit_x;
		logic [19:0] hit_y;
		logic        hit_vertical;
		logic [7:0]  hit_content;
		logic        found_hit;
		logic [15:0] angle_out;
		logic        facing_down;
		logic        facing_right;
	} rsp_t;

	typedef struct packed {
		logic [4:0] op;
		logic       vert;
	} cmd_t;

	typedef struct packed {
		logic cor_last;
		logic div_last;
		logic sq_last;
		logic clr_last;
		logic is_write;
		logic strip_ok;
		logic c_zero;
		logic s_zero;
		logic in_map;
		logic oob;
		logic rd_hit;
		logic h_found;
		logic v_found;
	} stat_t;

	function automatic logic signed [Z_W-1:0] atan_lut(input logic [3:0] i);
		logic signed [Z_W-1:0] r;
		case (i)
			4'd0:    r = 18'sd8192;
			4'd1:    r = 18'sd4836;
			4'd2:    r = 18'sd2555;
			4'd3:    r = 18'sd1297;
			4'd4:    r = 18'sd651;
			4'd5:    r = 18'sd326;
			4'd6:    r = 18'sd163;
			4'd7:    r = 18'sd81;
			4'd8:    r = 18'sd41;
			4'd9:    r = 18'sd20;
			4'd10:   r = 18'sd10;
			4'd11:   r = 18'sd5;
			4'd12:   r = 18'sd3;
			4'd13:   r = 18'sd1;
			4'd14:   r = 18'sd1;
			default: r = 18'sd0;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

[rtl/grid_ray_wall_intersect_top.sv]
// A cell write goes through the dispatch state; a cast runs 16 CORDIC steps, then
// per search two bit-serial divisions plus a probe and a map check per grid crossing, and
// per hit a square root. Most of a cast is spent in the single-bit divider and map RAM reads.
// Throughput: one request at a time; the next is taken once the result is registered.
// Reset: arst_n clears player position and control; the tile map is then zeroed by a clearing
// pass over every map cell during which no request is taken (config writes still land).
`default_nettype none

module grid_ray_wall_intersect_top (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire grwi_pkg::req_t               in_data,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output grwi_pkg::rsp_t                    out_data,
	input  wire logic                         cfg_we,
	input  wire logic                         cfg_addr,
	input  wire logic [grwi_pkg::COORD_W-1:0] cfg_wdata
);

	grwi_pkg::cmd_t cmd;
	grwi_pkg::stat_t stat;

	grwi_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	grwi_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.stat     (stat),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_wdata(cfg_wdata),
		.in_data  (in_data),
		.out_data (out_data)
	);

endmodule

`default_nettype wire

[rtl/grwi_ram.sv]
`default_nettype none

module grwi_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

[rtl/grwi_dp.sv]
`default_nettype none

module grwi_dp (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire grwi_pkg::cmd_t             cmd,
	output grwi_pkg::stat_t                 stat,
	input  wire logic                       cfg_we,
	input  wire logic                       cfg_addr,
	input  wire logic [grwi_pkg::COORD_W-1:0] cfg_wdata,
	input  wire grwi_pkg::req_t             in_data,
	output grwi_pkg::rsp_t                  out_data
);

	localparam int PW = grwi_pkg::POS_W;
	localparam int TW = grwi_pkg::TRIG_W;
	localparam int ZW = grwi_pkg::Z_W;
	localparam int CW = grwi_pkg::COORD_W;
	localparam int AW = grwi_pkg::ADDR_W;

	logic [CW-1:0] px_q, py_q;
	grwi_pkg::req_t req_q;
	logic down_q, right_q;

	logic signed [TW-1:0] cx_q, cy_q, cos_q, sin_q;
	logic signed [ZW-1:0] cz_q;
	logic neg_q;
	logic [grwi_pkg::IT_W-1:0] it_q;

	logic signed [PW-1:0] tx_q, ty_q, sx_q, sy_q;
	logic [grwi_pkg::DVD_W-1:0] dvd_q;
	logic [grwi_pkg::DVS_W-1:0] dvs_q, rem_q;
	logic qneg_q;

	logic hf_q, vf_q;
	logic [CW-1:0] hx_q, hy_q, vx_q, vy_q;
	logic [7:0] hc_q, vc_q;
	logic [grwi_pkg::DIST_W-1:0] hd_q, vd_q;
	logic [2*CW-1:0] mul_q, acc_q;
	logic [grwi_pkg::SQ_W-1:0] sqv_q, sqr_q;
	logic [AW-1:0] clr_q;
	grwi_pkg::rsp_t out_q;

	logic [7:0] rdata;
	logic ram_we;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [7:0] ram_wdata;

	// angle fold into [-pi/2, pi/2]
	logic signed [ZW-1:0] z_raw, z_fold;
	logic z_neg;
	always_comb begin
		z_raw = ZW'(signed'(req_q.ray_angle));
		z_fold = z_raw;
		z_neg = 1'b0;
		if (z_raw > ZW'(grwi_pkg::QUARTER)) begin
			z_fold = z_raw - ZW'(grwi_pkg::HALF);
			z_neg = 1'b1;
		end else if (z_raw < -ZW'(grwi_pkg::QUARTER)) begin
			z_fold = z_raw + ZW'(grwi_pkg::HALF);
			z_neg = 1'b1;
		end
	end

	logic signed [TW-1:0] xs, ys;
	assign xs = cx_q >>> it_q[3:0];
	assign ys = cy_q >>> it_q[3:0];

	logic signed [PW-1:0] pxs, pys, tx0, ty0;
	assign pxs = signed'(PW'(px_q));
	assign pys = signed'(PW'(py_q));
	assign tx0 = signed'(PW'({px_q[CW-1:grwi_pkg::TILE_LOG2], {grwi_pkg::TILE_LOG2{1'b0}}}))
		+ (right_q ? grwi_pkg::TILE_S : PW'(0));
	assign ty0 = signed'(PW'({py_q[CW-1:grwi_pkg::TILE_LOG2], {grwi_pkg::TILE_LOG2{1'b0}}}))
		+ (down_q ? grwi_pkg::TILE_S : PW'(0));

	// intercept division operands
	logic signed [grwi_pkg::DIFF_W-1:0] diff;
	logic signed [TW-1:0] trig_n, trig_d;
	logic signed [grwi_pkg::DIFF_W+TW-1:0] prod;
	logic [grwi_pkg::DIFF_W+TW-1:0] nabs;
	logic [TW-1:0] nmag, dabs;
	always_comb begin
		diff = cmd.vert ? grwi_pkg::DIFF_W'(tx_q - pxs) : grwi_pkg::DIFF_W'(ty_q - pys);
		trig_n = cmd.vert ? sin_q : cos_q;
		trig_d = cmd.vert ? cos_q : sin_q;
		prod = diff * trig_n;
		nabs = prod[grwi_pkg::DIFF_W+TW-1] ? unsigned'(-prod) : unsigned'(prod);
		nmag = trig_n[TW-1] ? unsigned'(-trig_n) : unsigned'(trig_n);
		dabs = trig_d[TW-1] ? unsigned'(-trig_d) : unsigned'(trig_d);
	end

	logic [grwi_pkg::DVS_W:0] trial;
	logic ge;
	logic signed [PW-1:0] qs;
	assign trial = {rem_q, dvd_q[grwi_pkg::DVD_W-1]};
	assign ge = trial >= {1'b0, dvs_q};
	assign qs = qneg_q ? -signed'(PW'(dvd_q)) : signed'(PW'(dvd_q));

	// probe point and map bounds
	logic signed [PW-1:0] prx, pry;
	logic in_map, oob;
	logic [grwi_pkg::ROW_W-1:0] prow;
	logic [grwi_pkg::COL_W-1:0] pcol;
	always_comb begin
		prx = tx_q - ((cmd.vert && !right_q) ? grwi_pkg::UNIT_S : PW'(0));
		pry = ty_q - ((!cmd.vert && !down_q) ? grwi_pkg::UNIT_S : PW'(0));
		in_map = (tx_q >= 0) && (ty_q >= 0) && (tx_q <= grwi_pkg::MAP_XMAX)
			&& (ty_q <= grwi_pkg::MAP_YMAX);
		oob = (prx < 0) || (pry < 0) || (prx >= grwi_pkg::MAP_XMAX)
			|| (pry >= grwi_pkg::MAP_YMAX);
		prow = grwi_pkg::ROW_W'(pry >>> grwi_pkg::TILE_LOG2);
		pcol = grwi_pkg::COL_W'(prx >>> grwi_pkg::TILE_LOG2);
	end

	// distance operands
	logic signed [CW:0] ddx, ddy;
	logic [CW-1:0] dx, dy;
	always_comb begin
		ddx = signed'({1'b0, cmd.vert ? vx_q : hx_q}) - signed'({1'b0, px_q});
		ddy = signed'({1'b0, cmd.vert ? vy_q : hy_q}) - signed'({1'b0, py_q});
		dx = CW'(ddx[CW] ? unsigned'(-ddx) : unsigned'(ddx));
		dy = CW'(ddy[CW] ? unsigned'(-ddy) : unsigned'(ddy));
	end

	logic [grwi_pkg::SQ_W-1:0] sq_bit, sq_try;
	assign sq_bit = grwi_pkg::SQ_W'(1) << {it_q, 1'b0};
	assign sq_try = sqr_q + sq_bit;

	always_comb begin
		ram_we = 1'b0;
		ram_waddr = clr_q;
		ram_wdata = 8'd0;
		if (cmd.op == grwi_pkg::OP_CLEAR) begin
			ram_we = 1'b1;
		end else if (cmd.op == grwi_pkg::OP_WRITE) begin
			ram_we = (32'(req_q.cell_row) < grwi_pkg::MAP_ROWS)
				&& (32'(req_q.cell_col) < grwi_pkg::MAP_COLS);
			ram_waddr = AW'(32'(req_q.cell_row) * grwi_pkg::MAP_COLS + 32'(req_q.cell_col));
			ram_wdata = req_q.cell_value;
		end
		ram_raddr = AW'(32'(prow) * grwi_pkg::MAP_COLS + 32'(pcol));
	end

	grwi_ram #(
		.WIDTH(8),
		.DEPTH(grwi_pkg::MAP_DEPTH)
	) u_map (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			px_q <= '0;
			py_q <= '0;
			clr_q <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_addr)
					grwi_pkg::REG_PLAYER_X: px_q <= cfg_wdata;
					grwi_pkg::REG_PLAYER_Y: py_q <= cfg_wdata;
					default: ;
				endcase
			end
			if (cmd.op == grwi_pkg::OP_CLEAR) begin
				clr_q <= clr_q + AW'(1);
			end
		end
	end

	logic use_v;
	logic [grwi_pkg::DIST_W-1:0] dsel;

	always_comb begin
		use_v = vf_q && (!hf_q || vd_q < hd_q);
		dsel = use_v ? vd_q : hd_q;
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			grwi_pkg::OP_LOAD: begin
				req_q <= in_data;
				down_q <= (in_data.ray_angle != 16'd0)
					&& (32'(in_data.ray_angle) < grwi_pkg::HALF);
				right_q <= (32'(in_data.ray_angle) < grwi_pkg::QUARTER)
					|| (32'(in_data.ray_angle) > 3 * grwi_pkg::QUARTER);
				hf_q <= 1'b0;
				vf_q <= 1'b0;
				hx_q <= '0;
				hy_q <= '0;
				vx_q <= '0;
				vy_q <= '0;
				hc_q <= '0;
				vc_q <= '0;
			end
			grwi_pkg::OP_COR_INIT: begin
				cx_q <= TW'(grwi_pkg::CORDIC_X0);
				cy_q <= '0;
				cz_q <= z_fold;
				neg_q <= z_neg;
				it_q <= '0;
			end
			grwi_pkg::OP_COR_STEP: begin
				if (!cz_q[ZW-1]) begin
					cx_q <= cx_q - ys;
					cy_q <= cy_q + xs;
					cz_q <= cz_q - grwi_pkg::atan_lut(it_q[3:0]);
				end else begin
					cx_q <= cx_q + ys;
					cy_q <= cy_q - xs;
					cz_q <= cz_q + grwi_pkg::atan_lut(it_q[3:0]);
				end
				it_q <= it_q + grwi_pkg::IT_W'(1);
			end
			grwi_pkg::OP_TRIG_FIX: begin
				// exact axes get an exact zero component
				if (req_q.ray_angle == 16'd0 || 32'(req_q.ray_angle) == grwi_pkg::HALF) begin
					sin_q <= '0;
				end else begin
					sin_q <= neg_q ? -cy_q : cy_q;
				end
				if (32'(req_q.ray_angle) == grwi_pkg::QUARTER
					|| 32'(req_q.ray_angle) == 3 * grwi_pkg::QUARTER) begin
					cos_q <= '0;
				end else begin
					cos_q <= neg_q ? -cx_q : cx_q;
				end
			end
			grwi_pkg::OP_SRCH_INIT: begin
				if (cmd.vert) begin
					tx_q <= tx0;
				end else begin
					ty_q <= ty0;
				end
			end
			grwi_pkg::OP_DIVA_INIT: begin
				dvd_q <= grwi_pkg::DVD_W'(nabs + (grwi_pkg::DIFF_W+TW)'(dabs >> 1));
				dvs_q <= grwi_pkg::DVS_W'(dabs);
				rem_q <= '0;
				qneg_q <= prod[grwi_pkg::DIFF_W+TW-1] ^ trig_d[TW-1];
				it_q <= '0;
			end
			grwi_pkg::OP_DIVB_INIT: begin
				dvd_q <= grwi_pkg::DVD_W'({nmag, {grwi_pkg::TILE_LOG2{1'b0}}})
					+ grwi_pkg::DVD_W'(dabs >> 1);
				dvs_q <= grwi_pkg::DVS_W'(dabs);
				rem_q <= '0;
				qneg_q <= 1'b0;
				it_q <= '0;
			end
			grwi_pkg::OP_DIV_STEP: begin
				rem_q <= ge ? grwi_pkg::DVS_W'(trial - {1'b0, dvs_q})
					: trial[grwi_pkg::DVS_W-1:0];
				dvd_q <= {dvd_q[grwi_pkg::DVD_W-2:0], ge};
				it_q <= it_q + grwi_pkg::IT_W'(1);
			end
			grwi_pkg::OP_DIVA_DONE: begin
				if (cmd.vert) begin
					ty_q <= pys + qs;
				end else begin
					tx_q <= pxs + qs;
				end
			end
			grwi_pkg::OP_DIVB_DONE: begin
				if (cmd.vert) begin
					sy_q <= down_q ? qs : -qs;
					sx_q <= right_q ? grwi_pkg::TILE_S : -grwi_pkg::TILE_S;
				end else begin
					sx_q <= right_q ? qs : -qs;
					sy_q <= down_q ? grwi_pkg::TILE_S : -grwi_pkg::TILE_S;
				end
			end
			grwi_pkg::OP_PROBE: begin
				// outside the map counts as a wall with empty content
				if (in_map && oob) begin
					if (cmd.vert) begin
						vf_q <= 1'b1;
						vx_q <= tx_q[CW-1:0];
						vy_q <= ty_q[CW-1:0];
						vc_q <= 8'd0;
					end else begin
						hf_q <= 1'b1;
						hx_q <= tx_q[CW-1:0];
						hy_q <= ty_q[CW-1:0];
						hc_q <= 8'd0;
					end
				end
			end
			grwi_pkg::OP_CHECK: begin
				if (rdata != 8'd0) begin
					if (cmd.vert) begin
						vf_q <= 1'b1;
						vx_q <= tx_q[CW-1:0];
						vy_q <= ty_q[CW-1:0];
						vc_q <= rdata;
					end else begin
						hf_q <= 1'b1;
						hx_q <= tx_q[CW-1:0];
						hy_q <= ty_q[CW-1:0];
						hc_q <= rdata;
					end
				end else begin
					tx_q <= tx_q + sx_q;
					ty_q <= ty_q + sy_q;
				end
			end
			grwi_pkg::OP_MUL_X: begin
				mul_q <= dx * dx;
			end
			grwi_pkg::OP_MUL_Y: begin
				acc_q <= mul_q;
				mul_q <= dy * dy;
			end
			grwi_pkg::OP_SQ_INIT: begin
				sqv_q <= grwi_pkg::SQ_W'(acc_q) + grwi_pkg::SQ_W'(mul_q);
				sqr_q <= '0;
				it_q <= grwi_pkg::IT_W'(grwi_pkg::SQ_ITERS - 1);
			end
			grwi_pkg::OP_SQ_STEP: begin
				if (sqv_q >= sq_try) begin
					sqv_q <= sqv_q - sq_try;
					sqr_q <= (sqr_q >> 1) + sq_bit;
				end else begin
					sqr_q <= sqr_q >> 1;
				end
				it_q <= it_q - grwi_pkg::IT_W'(1);
			end
			grwi_pkg::OP_SQ_DONE: begin
				if (cmd.vert) begin
					vd_q <= sqr_q[grwi_pkg::DIST_W-1:0];
				end else begin
					hd_q <= sqr_q[grwi_pkg::DIST_W-1:0];
				end
			end
			grwi_pkg::OP_OUT: begin
				out_q.strip_out <= req_q.strip_id;
				if (!hf_q && !vf_q) begin
					out_q.hit_distance <= grwi_pkg::COORD_MAX;
				end else if (dsel > grwi_pkg::DIST_W'(grwi_pkg::COORD_MAX)) begin
					out_q.hit_distance <= grwi_pkg::COORD_MAX;
				end else begin
					out_q.hit_distance <= dsel[CW-1:0];
				end
				out_q.hit_x <= use_v ? vx_q : hx_q;
				out_q.hit_y <= use_v ? vy_q : hy_q;
				out_q.hit_vertical <= use_v;
				out_q.hit_content <= use_v ? vc_q : hc_q;
				out_q.found_hit <= hf_q || vf_q;
				out_q.angle_out <= req_q.ray_angle;
				out_q.facing_down <= down_q;
				out_q.facing_right <= right_q;
			end
			default: ;
		endcase
	end

	always_comb begin
		stat.cor_last = it_q == grwi_pkg::IT_W'(grwi_pkg::CORDIC_ITERS - 1);
		stat.div_last = it_q == grwi_pkg::IT_W'(grwi_pkg::DIV_ITERS - 1);
		stat.sq_last = it_q == '0;
		stat.clr_last = clr_q == AW'(grwi_pkg::MAP_DEPTH - 1);
		stat.is_write = !req_q.func;
		stat.strip_ok = 32'(req_q.strip_id) < grwi_pkg::STRIP_COUNT;
		stat.c_zero = cos_q == '0;
		stat.s_zero = sin_q == '0;
		stat.in_map = in_map;
		stat.oob = oob;
		stat.rd_hit = rdata != 8'd0;
		stat.h_found = hf_q;
		stat.v_found = vf_q;
	end

	assign out_data = out_q;

endmodule

`default_nettype wire

[rtl/grwi_ctrl.sv]
`default_nettype none

module grwi_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  wire logic            out_ready,
	input  wire grwi_pkg::stat_t stat,
	output grwi_pkg::cmd_t       cmd
);

	localparam logic [4:0] S_CLEAR     = 5'd0;
	localparam logic [4:0] S_IDLE      = 5'd1;
	localparam logic [4:0] S_DISPATCH  = 5'd2;
	localparam logic [4:0] S_COR       = 5'd3;
	localparam logic [4:0] S_TRIG      = 5'd4;
	localparam logic [4:0] S_START     = 5'd5;
	localparam logic [4:0] S_DIVA_INIT = 5'd6;
	localparam logic [4:0] S_DIVA      = 5'd7;
	localparam logic [4:0] S_DIVA_DONE = 5'd8;
	localparam logic [4:0] S_DIVB_INIT = 5'd9;
	localparam logic [4:0] S_DIVB      = 5'd10;
	localparam logic [4:0] S_DIVB_DONE = 5'd11;
	localparam logic [4:0] S_PROBE     = 5'd12;
	localparam logic [4:0] S_CHECK     = 5'd13;
	localparam logic [4:0] S_DSTART    = 5'd14;
	localparam logic [4:0] S_MULX      = 5'd15;
	localparam logic [4:0] S_MULY      = 5'd16;
	localparam logic [4:0] S_SQINIT    = 5'd17;
	localparam logic [4:0] S_SQ        = 5'd18;
	localparam logic [4:0] S_SQDONE    = 5'd19;
	localparam logic [4:0] S_EMIT      = 5'd20;

	logic [4:0] state_q, state_d;
	logic vert_q, vert_d;
	logic out_valid_q;

	always_comb begin
		state_d = state_q;
		vert_d = vert_q;
		cmd.op = grwi_pkg::OP_NONE;
		in_ready = 1'b0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.op = grwi_pkg::OP_CLEAR;
				if (stat.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.op = grwi_pkg::OP_LOAD;
					state_d = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				if (stat.is_write) begin
					cmd.op = grwi_pkg::OP_WRITE;
					state_d = S_IDLE;
				end else if (!stat.strip_ok) begin
					state_d = S_IDLE;
				end else begin
					cmd.op = grwi_pkg::OP_COR_INIT;
					state_d = S_COR;
				end
			end
			S_COR: begin
				cmd.op = grwi_pkg::OP_COR_STEP;
				if (stat.cor_last) begin
					state_d = S_TRIG;
				end
			end
			S_TRIG: begin
				cmd.op = grwi_pkg::OP_TRIG_FIX;
				vert_d = 1'b0;
				state_d = S_START;
			end
			S_START: begin
				// axis-parallel: this search cannot hit
				if (vert_q ? stat.c_zero : stat.s_zero) begin
					state_d = vert_q ? S_DSTART : S_START;
					vert_d = !vert_q;
				end else begin
					cmd.op = grwi_pkg::OP_SRCH_INIT;
					state_d = S_DIVA_INIT;
				end
			end
			S_DIVA_INIT: begin
				cmd.op = grwi_pkg::OP_DIVA_INIT;
				state_d = S_DIVA;
			end
			S_DIVA: begin
				cmd.op = grwi_pkg::OP_DIV_STEP;
				if (stat.div_last) begin
					state_d = S_DIVA_DONE;
				end
			end
			S_DIVA_DONE: begin
				cmd.op = grwi_pkg::OP_DIVA_DONE;
				state_d = S_DIVB_INIT;
			end
			S_DIVB_INIT: begin
				cmd.op = grwi_pkg::OP_DIVB_INIT;
				state_d = S_DIVB;
			end
			S_DIVB: begin
				cmd.op = grwi_pkg::OP_DIV_STEP;
				if (stat.div_last) begin
					state_d = S_DIVB_DONE;
				end
			end
			S_DIVB_DONE: begin
				cmd.op = grwi_pkg::OP_DIVB_DONE;
				state_d = S_PROBE;
			end
			S_PROBE: begin
				if (!stat.in_map) begin
					state_d = vert_q ? S_DSTART : S_START;
					vert_d = !vert_q;
				end else if (stat.oob) begin
					cmd.op = grwi_pkg::OP_PROBE;
					state_d = vert_q ? S_DSTART : S_START;
					vert_d = !vert_q;
				end else begin
					cmd.op = grwi_pkg::OP_PROBE;
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				cmd.op = grwi_pkg::OP_CHECK;
				if (stat.rd_hit) begin
					state_d = vert_q ? S_DSTART : S_START;
					vert_d = !vert_q;
				end else begin
					state_d = S_PROBE;
				end
			end
			S_DSTART: begin
				if (vert_q ? stat.v_found : stat.h_found) begin
					state_d = S_MULX;
				end else begin
					state_d = vert_q ? S_EMIT : S_DSTART;
					vert_d = 1'b1;
				end
			end
			S_MULX: begin
				cmd.op = grwi_pkg::OP_MUL_X;
				state_d = S_MULY;
			end
			S_MULY: begin
				cmd.op = grwi_pkg::OP_MUL_Y;
				state_d = S_SQINIT;
			end
			S_SQINIT: begin
				cmd.op = grwi_pkg::OP_SQ_INIT;
				state_d = S_SQ;
			end
			S_SQ: begin
				cmd.op = grwi_pkg::OP_SQ_STEP;
				if (stat.sq_last) begin
					state_d = S_SQDONE;
				end
			end
			S_SQDONE: begin
				cmd.op = grwi_pkg::OP_SQ_DONE;
				state_d = vert_q ? S_EMIT : S_DSTART;
				vert_d = 1'b1;
			end
			S_EMIT: begin
				if (!out_valid_q || out_ready) begin
					cmd.op = grwi_pkg::OP_OUT;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
		cmd.vert = vert_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			vert_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			vert_q <= vert_d;
			if (cmd.op == grwi_pkg::OP_OUT) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	a_no_req_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLEAR) |-> !in_ready)
		else $error("request taken during map clear");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == grwi_pkg::OP_OUT) |-> (!out_valid_q || out_ready))
		else $error("pending result overwritten");

	a_accept_dispatch: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == S_DISPATCH))
		else $error("accepted request not dispatched");

	a_valid_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == S_EMIT))
		else $error("result raised outside emit");

endmodule

`default_nettype wire

[test/grid_ray_wall_intersect_top_tb.sv]
`default_nettype none

module grid_ray_wall_intersect_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import grwi_pkg::*;

	localparam logic FUNC_WRITE = 1'b0;
	localparam logic FUNC_CAST  = 1'b1;
	localparam longint TILE_W   = 64 * 256;
	localparam longint MAP_W    = TILE_W * 32;
	localparam longint SAT      = 20'hFFFFF;
	localparam int ARCTAN [16] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81,
		41, 20, 10, 5, 3, 1, 1, 0};

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	req_t in_data;
	logic out_valid;
	logic out_ready;
	rsp_t out_data;
	logic cfg_we;
	logic cfg_addr;
	logic [COORD_W-1:0] cfg_wdata;

	grid_ray_wall_intersect_top i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_wdata(cfg_wdata)
	);

	// shadow of the block's state
	logic [7:0] tiles [32][32];
	logic [19:0] view_x, view_y;
	rsp_t ray_results_q[$];
	int errors = 0;
	int n_casts = 0, n_writes = 0, n_hits = 0, n_vert = 0, n_edge = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("** grid_ray_wall_intersect_top: FAILED **");
		$finish;
	end

	function automatic longint div_nearest(longint n, longint d);
		longint un, ud, q;
		un = n < 0 ? -n : n;
		ud = d < 0 ? -d : d;
		q = (un + ud / 2) / ud;
		return ((n < 0) != (d < 0)) ? -q : q;
	endfunction

	function automatic bit on_map(longint x, longint y);
		return x >= 0 && y >= 0 && x <= MAP_W && y <= MAP_W;
	endfunction

	// outside the map counts as a wall with content 0
	function automatic bit is_wall(longint x, longint y, output int cont);
		if (x < 0 || y < 0 || x >= MAP_W || y >= MAP_W) begin
			cont = 0;
			return 1'b1;
		end
		cont = tiles[y / TILE_W][x / TILE_W];
		return cont != 0;
	endfunction

	function automatic longint span(longint px, longint py, longint hx, longint hy);
		longint unsigned dx, dy, v, r, b;
		dx = hx > px ? hx - px : px - hx;
		dy = hy > py ? hy - py : py - hy;
		v = dx * dx + dy * dy;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic longint clip20(longint v);
		if (v < 0) return 0;
		return v > SAT ? SAT : v;
	endfunction

	function automatic rsp_t trace_ray(logic [15:0] ang, logic [9:0] strip);
		longint px, py, c, s, tx, ty, sx, sy, z, x, y, nx;
		longint hhx, hhy, vhx, vhy, hd, vd;
		int hcont, vcont, cont;
		bit down, right, hf, vf, usev, neg;
		rsp_t r;
		px = view_x;
		py = view_y;
		hhx = 0; hhy = 0; vhx = 0; vhy = 0; hd = 0; vd = 0;
		hcont = 0; vcont = 0; hf = 0; vf = 0; neg = 0;
		down = ang > 0 && ang < HALF;
		right = ang < QUARTER || ang > 3 * QUARTER;
		z = ang >= HALF ? longint'(ang) - 65536 : longint'(ang);
		x = CORDIC_X0;
		y = 0;
		if (z > QUARTER) begin
			z -= HALF;
			neg = 1;
		end else if (z < -QUARTER) begin
			z += HALF;
			neg = 1;
		end
		for (int i = 0; i < 16; i++) begin
			if (z >= 0) begin
				nx = x - (y >>> i);
				y = y + (x >>> i);
				z -= ARCTAN[i];
			end else begin
				nx = x + (y >>> i);
				y = y - (x >>> i);
				z += ARCTAN[i];
			end
			x = nx;
		end
		c = neg ? -x : x;
		s = neg ? -y : y;
		if (ang == 0 || ang == HALF) s = 0;
		if (ang == QUARTER || ang == 3 * QUARTER) c = 0;

		if (s != 0) begin
			ty = (py / TILE_W) * TILE_W + (down ? TILE_W : 0);
			tx = px + div_nearest((ty - py) * c, s);
			sx = div_nearest(TILE_W * (c < 0 ? -c : c), s < 0 ? -s : s);
			if (!right) sx = -sx;
			sy = down ? TILE_W : -TILE_W;
			while (on_map(tx, ty)) begin
				if (is_wall(tx, ty - (down ? 0 : 256), cont)) begin
					hf = 1; hhx = tx; hhy = ty; hcont = cont;
					break;
				end
				tx += sx;
				ty += sy;
			end
		end
		if (c != 0) begin
			tx = (px / TILE_W) * TILE_W + (right ? TILE_W : 0);
			ty = py + div_nearest((tx - px) * s, c);
			sy = div_nearest(TILE_W * (s < 0 ? -s : s), c < 0 ? -c : c);
			if (!down) sy = -sy;
			sx = right ? TILE_W : -TILE_W;
			while (on_map(tx, ty)) begin
				if (is_wall(tx - (right ? 0 : 256), ty, cont)) begin
					vf = 1; vhx = tx; vhy = ty; vcont = cont;
					break;
				end
				tx += sx;
				ty += sy;
			end
		end
		if (hf) hd = span(px, py, hhx, hhy);
		if (vf) vd = span(px, py, vhx, vhy);
		// ties go to the horizontal search
		usev = vf && (!hf || vd < hd);

		r.strip_out = strip;
		if (usev) begin
			r.hit_distance = 20'(clip20(vd));
			r.hit_x = 20'(clip20(vhx));
			r.hit_y = 20'(clip20(vhy));
			r.hit_vertical = 1'b1;
			r.hit_content = vcont[7:0];
		end else begin
			r.hit_distance = hf ? 20'(clip20(hd)) : 20'(SAT);
			r.hit_x = 20'(clip20(hhx));
			r.hit_y = 20'(clip20(hhy));
			r.hit_vertical = 1'b0;
			r.hit_content = hcont[7:0];
		end
		r.found_hit = hf || vf;
		r.angle_out = ang;
		r.facing_down = down;
		r.facing_right = right;
		return r;
	endfunction

	// response checker
	always @(posedge clk) begin
		rsp_t e;
		if (arst_n && out_valid && out_ready) begin
			if (ray_results_q.size() == 0) begin
				$error("unexpected response strip_out=%0d", out_data.strip_out);
				errors++;
			end else begin
				e = ray_results_q.pop_front();
				if (out_data.strip_out !== e.strip_out) begin
					$error("strip_out exp %0d got %0d", e.strip_out, out_data.strip_out);
					errors++;
				end
				if (out_data.hit_distance !== e.hit_distance) begin
					$error("hit_distance exp %0d got %0d", e.hit_distance,
						out_data.hit_distance);
					errors++;
				end
				if (out_data.hit_x !== e.hit_x) begin
					$error("hit_x exp %0d got %0d", e.hit_x, out_data.hit_x);
					errors++;
				end
				if (out_data.hit_y !== e.hit_y) begin
					$error("hit_y exp %0d got %0d", e.hit_y, out_data.hit_y);
					errors++;
				end
				if (out_data.hit_vertical !== e.hit_vertical) begin
					$error("hit_vertical exp %0d got %0d", e.hit_vertical,
						out_data.hit_vertical);
					errors++;
				end
				if (out_data.hit_content !== e.hit_content) begin
					$error("hit_content exp %0d got %0d", e.hit_content,
						out_data.hit_content);
					errors++;
				end
				if (out_data.found_hit !== e.found_hit) begin
					$error("found_hit exp %0d got %0d", e.found_hit, out_data.found_hit);
					errors++;
				end
				if (out_data.angle_out !== e.angle_out) begin
					$error("angle_out exp %0d got %0d", e.angle_out, out_data.angle_out);
					errors++;
				end
				if (out_data.facing_down !== e.facing_down) begin
					$error("facing_down exp %0d got %0d", e.facing_down,
						out_data.facing_down);
					errors++;
				end
				if (out_data.facing_right !== e.facing_right) begin
					$error("facing_right exp %0d got %0d", e.facing_right,
						out_data.facing_right);
					errors++;
				end
			end
		end
	end

	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	task automatic send_req(req_t r);
		rsp_t e;
		if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			@(negedge clk);
			in_valid = 1'b0;
			repeat ($urandom_range(1, 12)) @(negedge clk);
		end else begin
			@(negedge clk);
		end
		in_valid = 1'b1;
		in_data = r;
		do @(posedge clk); while (!in_ready);
		if (r.func == FUNC_WRITE) begin
			tiles[r.cell_row][r.cell_col] = r.cell_value;
			n_writes++;
		end else begin
			e = trace_ray(r.ray_angle, r.strip_id);
			ray_results_q.push_back(e);
			n_casts++;
			if (e.found_hit) n_hits++;
			if (e.hit_vertical) n_vert++;
			if (e.found_hit && e.hit_content == 0) n_edge++;
		end
	endtask

	task automatic write_cell(int row, int col, int val);
		req_t r;
		r = $urandom;
		r.func = FUNC_WRITE;
		r.cell_row = 5'(row);
		r.cell_col = 5'(col);
		r.cell_value = 8'(val);
		send_req(r);
	endtask

	task automatic cast(int ang, int strip);
		req_t r;
		r = $urandom;
		r.func = FUNC_CAST;
		r.ray_angle = 16'(ang);
		r.strip_id = 10'(strip);
		send_req(r);
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid = 1'b0;
		wait (ray_results_q.size() == 0);
		// a trailing cell write may still be in flight
		repeat (20) @(posedge clk);
	endtask

	task automatic set_view(logic [19:0] x, logic [19:0] y);
		drain();
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_addr = REG_PLAYER_X;
		cfg_wdata = x;
		@(negedge clk);
		cfg_addr = REG_PLAYER_Y;
		cfg_wdata = y;
		@(posedge clk);
		view_x = x;
		view_y = y;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// empty map: each ray ends on the map border with content 0 or finds no wall
	task automatic test_border_hits();
		set_view(20'd0, 20'd0);
		cast(0, 0);
		cast(QUARTER, 1023);
		set_view(20'd262272, 20'd262272);
		cast(HALF, 5);
		cast(3 * QUARTER, 6);
		cast(1, 7);
		cast(65535, 8);
		cast(8192, 9);
		set_view(20'd524288, 20'd524288);
		cast(40960, 10);
		cast(0, 11);
	endtask

	task automatic test_cell_writes();
		write_cell(0, 0, 255);
		write_cell(31, 31, 1);
		write_cell(0, 31, 128);
		write_cell(31, 0, 77);
		write_cell(15, 16, 9);
		write_cell(16, 15, 0);
		set_view(20'd2000, 20'd2000);
		cast(HALF + 4096, 12);
		cast(3 * QUARTER + 1, 13);
		set_view(20'hFFFFF, 20'hFFFFF);
		cast(8192, 14);
		cast(HALF + 8192, 15);
	endtask

	task automatic random_phase(int idle, int stall, int count);
		int ang;
		send_idle_pct = idle;
		recv_stall_pct = stall;
		for (int i = 0; i < count; i++) begin
			if (i % 50 == 0) begin
				if ($urandom_range(9) == 0)
					set_view(20'($urandom), 20'($urandom));
				else
					set_view(20'($urandom_range(524288)), 20'($urandom_range(524288)));
			end
			if ($urandom_range(3) == 0) begin
				write_cell($urandom_range(31), $urandom_range(31),
					$urandom_range(1) ? 0 : $urandom_range(255));
			end else begin
				case ($urandom_range(9))
					0: ang = $urandom_range(3) * QUARTER;
					1: ang = $urandom_range(3) * QUARTER + ($urandom_range(1) ? 1 : -1);
					default: ang = $urandom_range(65535);
				endcase
				cast(ang & 16'hFFFF, $urandom_range(1023));
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_ready = 1'b0;
		cfg_we = 1'b0;
		cfg_addr = REG_PLAYER_X;
		cfg_wdata = '0;
		view_x = '0;
		view_y = '0;
		foreach (tiles[r, c]) tiles[r][c] = '0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;

		test_border_hits();
		test_cell_writes();
		random_phase(0, 0, 210);
		random_phase(66, 0, 210);
		random_phase(0, 66, 210);
		random_phase(36, 36, 210);

		drain();
		repeat (400) @(posedge clk);
		$display("covered %0d casts (%0d hits, %0d vertical, %0d on map edge), %0d cell writes",
			n_casts, n_hits, n_vert, n_edge, n_writes);
		$display("viewer moved between phases, including out-of-map positions and all stall mixes");
		if (errors == 0) begin
			$display("** grid_ray_wall_intersect_top: PASSED **");
		end else begin
			$display("** grid_ray_wall_intersect_top: FAILED **");
		end
		$finish;
	end

endmodule

`default_nettype wire

[sim.f]
rtl/grwi_pkg.sv
rtl/grwi_ram.sv
rtl/grwi_dp.sv
rtl/grwi_ctrl.sv
rtl/grid_ray_wall_intersect_top.sv
test/grid_ray_wall_intersect_top_tb.sv
